// ===== hw/rtl/olalloc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package olalloc_pkg;

    localparam int MAX_LINES_DEF     = 64;
    localparam int PROBE_COUNT_DEF   = 10;
    localparam int RESTRICTED_PROBES = 5;

    localparam int PROBE_W  = 6;
    localparam int PROBES_W = 60;
    localparam int LINE_W   = 6;
    localparam int CNT_W    = PROBE_W + 1;
    localparam int KIND_W   = 2;

    localparam logic REQ_ALLOC   = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    localparam logic [KIND_W-1:0] KIND_TOP_SCROLL    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BOTTOM_SCROLL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TOP_STATIC    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_BOTTOM_STATIC = 2'd3;

    localparam logic [CNT_W-1:0] MIN_COUNT = 7'd2;

endpackage

`default_nettype wire

// ===== hw/rtl/olalloc_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface olalloc_req_if;
    import olalloc_pkg::*;

    logic                valid;
    logic                ready;
    logic                req_type;
    logic [KIND_W-1:0]   kind;
    logic [LINE_W-1:0]   release_line;
    logic [PROBES_W-1:0] probe_bits;

    modport source (output valid, output req_type, output kind, output release_line,
                    output probe_bits, input ready);
    modport sink   (input valid, input req_type, input kind, input release_line,
                    input probe_bits, output ready);
endinterface

interface olalloc_res_if;
    import olalloc_pkg::*;

    logic              valid;
    logic              ready;
    logic              granted;
    logic [LINE_W-1:0] line;

    modport source (output valid, output granted, output line, input ready);
    modport sink   (input valid, input granted, input line, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/overlay_line_allocator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Flow: a scrolling request tries its probes in turn, each through the remainder unit, then FINISH;
//   a static request scans lines (one line a cycle), then FINISH; a release goes straight to FINISH.
// Throughput: one request at a time; the next is taken the cycle after the result registers,
//   even while that result still waits on the output.
// Reset (i_rst_n low, synchronous): both pools free, line_count 64, no result pending.
module overlay_line_allocator #(
    parameter int MAX_LINES   = olalloc_pkg::MAX_LINES_DEF,
    parameter int PROBE_COUNT = olalloc_pkg::PROBE_COUNT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [olalloc_pkg::CNT_W-1:0]  i_cfg_wdata,
    olalloc_req_if.sink                    i_req,
    olalloc_res_if.source                  o_res
);
    import olalloc_pkg::*;

    localparam int LW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int IW = (PROBE_COUNT > 1) ? $clog2(PROBE_COUNT) : 1;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_PROBE  = 4'b0010,
        S_SCAN   = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_line_count, n_line_count;
    logic [MAX_LINES-1:0] r_scroll_busy, n_scroll_busy;
    logic [MAX_LINES-1:0] r_static_busy, n_static_busy;
    logic                 r_out_valid, n_out_valid;
    logic                 r_out_granted, n_out_granted;
    logic [LINE_W-1:0]    r_out_line, n_out_line;
    logic                 r_res_granted, n_res_granted;
    logic [LINE_W-1:0]    r_res_line, n_res_line;
    logic [KIND_W-1:0]    r_kind, n_kind;
    logic [IW-1:0]        r_idx, n_idx;
    logic [PROBES_W-1:0]  r_probes, n_probes;
    logic [LW-1:0]        r_scan, n_scan;

    logic [CNT_W-1:0]     w_count, w_half, w_last, w_n;
    logic                 w_restricted;
    logic                 rem_start, rem_busy;
    logic [PROBE_W-1:0]   rem_dividend, rem_out;
    logic [CNT_W-1:0]     rem_divisor;

    olalloc_rem_unit u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (rem_dividend),
        .i_divisor  (rem_divisor),
        .o_busy     (rem_busy),
        .o_rem      (rem_out)
    );

    always_comb begin
        w_count = r_line_count;
        if (w_count < MIN_COUNT) begin
            w_count = MIN_COUNT;
        end
        if (w_count > CNT_W'(MAX_LINES)) begin
            w_count = CNT_W'(MAX_LINES);
        end
        w_half = w_count >> 1;
        w_last = w_count - 1'b1;
        w_restricted = (32'(r_idx) < RESTRICTED_PROBES);
        w_n = (w_restricted && r_kind == KIND_BOTTOM_SCROLL) ?
              w_half + CNT_W'(rem_out) : CNT_W'(rem_out);
    end

    always_comb begin
        n_state       = r_state;
        n_line_count  = r_line_count;
        n_scroll_busy = r_scroll_busy;
        n_static_busy = r_static_busy;
        n_out_valid   = r_out_valid;
        n_out_granted = r_out_granted;
        n_out_line    = r_out_line;
        n_res_granted = r_res_granted;
        n_res_line    = r_res_line;
        n_kind        = r_kind;
        n_idx         = r_idx;
        n_probes      = r_probes;
        n_scan        = r_scan;
        rem_start     = 1'b0;
        rem_dividend  = r_probes[2*PROBE_W-1:PROBE_W];
        rem_divisor   = (32'(r_idx) + 32'd1 < RESTRICTED_PROBES) ? w_half : w_count;

        if (i_cfg_we) begin
            n_line_count = i_cfg_wdata;
        end
        if (r_out_valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_kind = i_req.kind;
                    if (i_req.req_type == REQ_RELEASE) begin
                        if ({1'b0, i_req.release_line} < w_count) begin
                            if (i_req.kind[1]) begin
                                n_static_busy[i_req.release_line[LW-1:0]] = 1'b0;
                            end else begin
                                n_scroll_busy[i_req.release_line[LW-1:0]] = 1'b0;
                            end
                        end
                        n_res_granted = 1'b0;
                        n_res_line    = '0;
                        n_state       = S_FINISH;
                    end else if (!i_req.kind[1]) begin
                        // first probe is always restricted to one half
                        n_probes     = i_req.probe_bits;
                        n_idx        = '0;
                        rem_start    = 1'b1;
                        rem_dividend = i_req.probe_bits[PROBE_W-1:0];
                        rem_divisor  = (RESTRICTED_PROBES > 0) ? w_half : w_count;
                        n_state      = S_PROBE;
                    end else begin
                        n_scan  = (i_req.kind == KIND_TOP_STATIC) ? '0 : w_last[LW-1:0];
                        n_state = S_SCAN;
                    end
                end
            end
            S_PROBE: begin
                if (!rem_busy) begin
                    if (!r_scroll_busy[w_n[LW-1:0]]) begin
                        n_scroll_busy[w_n[LW-1:0]] = 1'b1;
                        n_res_granted = 1'b1;
                        n_res_line    = LINE_W'(w_n[LW-1:0]);
                        n_state       = S_FINISH;
                    end else if (r_idx == IW'(PROBE_COUNT - 1)) begin
                        n_res_granted = 1'b0;
                        n_res_line    = '0;
                        n_state       = S_FINISH;
                    end else begin
                        n_idx     = r_idx + 1'b1;
                        n_probes  = r_probes >> PROBE_W;
                        rem_start = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                if (!r_static_busy[r_scan]) begin
                    n_static_busy[r_scan] = 1'b1;
                    n_res_granted = 1'b1;
                    n_res_line    = LINE_W'(r_scan);
                    n_state       = S_FINISH;
                end else if ((r_kind == KIND_TOP_STATIC) ?
                             (CNT_W'(r_scan) == w_last) : (r_scan == '0)) begin
                    n_res_granted = 1'b0;
                    n_res_line    = '0;
                    n_state       = S_FINISH;
                end else if (r_kind == KIND_TOP_STATIC) begin
                    n_scan = r_scan + 1'b1;
                end else begin
                    n_scan = r_scan - 1'b1;
                end
            end
            S_FINISH: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid   = 1'b1;
                    n_out_granted = r_res_granted;
                    n_out_line    = r_res_line;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_line_count  <= CNT_W'(MAX_LINES_DEF);
            r_scroll_busy <= '0;
            r_static_busy <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_line_count  <= n_line_count;
            r_scroll_busy <= n_scroll_busy;
            r_static_busy <= n_static_busy;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_granted <= n_out_granted;
        r_out_line    <= n_out_line;
        r_res_granted <= n_res_granted;
        r_res_line    <= n_res_line;
        r_kind        <= n_kind;
        r_idx         <= n_idx;
        r_probes      <= n_probes;
        r_scan        <= n_scan;
    end

    assign i_req.ready   = (r_state == S_IDLE);
    assign o_res.valid   = r_out_valid;
    assign o_res.granted = r_out_granted;
    assign o_res.line    = r_out_line;

`ifndef SYNTHESIS
    a_grant_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.granted |-> ({1'b0, o_res.line} < w_count))
        else $error("granted line beyond line count");
    a_deny_zero_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.granted |-> (o_res.line == '0))
        else $error("denied result carries a line");
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> (r_state != S_IDLE))
        else $error("request accepted but sequencer stayed idle");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/olalloc_rem_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Restoring remainder: one dividend bit per cycle, through all PROBE_W dividend bits per start.
module olalloc_rem_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [olalloc_pkg::PROBE_W-1:0]  i_dividend,
    input  logic [olalloc_pkg::CNT_W-1:0]    i_divisor,
    output logic                             o_busy,
    output logic [olalloc_pkg::PROBE_W-1:0]  o_rem
);
    import olalloc_pkg::*;

    localparam int STEP_W = $clog2(PROBE_W + 1);

    logic [STEP_W-1:0]  r_cnt, n_cnt;
    logic [PROBE_W-1:0] r_rem, n_rem;
    logic [PROBE_W-1:0] r_dvd, n_dvd;
    logic [CNT_W-1:0]   r_divisor, n_divisor;
    logic [CNT_W-1:0]   w_trial;

    always_comb begin
        n_cnt     = r_cnt;
        n_rem     = r_rem;
        n_dvd     = r_dvd;
        n_divisor = r_divisor;
        w_trial   = {r_rem, r_dvd[PROBE_W-1]};
        if (w_trial >= r_divisor) begin
            w_trial = w_trial - r_divisor;
        end
        if (i_start) begin
            n_cnt     = STEP_W'(PROBE_W);
            n_rem     = '0;
            n_dvd     = i_dividend;
            n_divisor = i_divisor;
        end else if (r_cnt != '0) begin
            // trial result is below the divisor, so it fits in PROBE_W bits
            n_rem = w_trial[PROBE_W-1:0];
            n_dvd = {r_dvd[PROBE_W-2:0], 1'b0};
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem     <= n_rem;
        r_dvd     <= n_dvd;
        r_divisor <= n_divisor;
    end

    assign o_busy = (r_cnt != '0);
    assign o_rem  = r_rem;

`ifndef SYNTHESIS
    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_busy) && (r_divisor != '0) |-> ({1'b0, o_rem} < r_divisor))
        else $error("remainder not below divisor");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> o_busy)
        else $error("start did not make unit busy");
    a_step_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_busy && !i_start |=> r_cnt == $past(r_cnt) - 1'b1)
        else $error("step counter skipped");
`endif

endmodule

`default_nettype wire
